>>> hdl/ffc_pkg.sv
package ffc_pkg;

  typedef enum logic [1:0] {
    WS_8  = 2'd0,
    WS_16 = 2'd1,
    WS_32 = 2'd2,
    WS_32B = 2'd3
  } word_size_t;

  typedef enum logic {
    ACT_FIX2FLT = 1'b0,
    ACT_FLT2FIX = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    REG_FRACTION_BITS = 1'b0,
    REG_WORD_SIZE     = 1'b1
  } reg_index_t;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [4:0] FRAC_RESET = 5'd16;

  typedef struct packed {
    logic [4:0] frac;
    logic [1:0] wsel;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] operand_bits;
  } req_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        saturated;
  } rsp_t;

endpackage

>>> hdl/ffc_if.sv
interface ffc_in_if;
  import ffc_pkg::*;
  logic valid;
  logic ready;
  req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface ffc_out_if;
  import ffc_pkg::*;
  logic valid;
  logic ready;
  rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

>>> hdl/ffc_convert.sv
module ffc_convert
  import ffc_pkg::*;
(
  input  req_t req,
  input  cfg_t cfg,
  output rsp_t rsp
);

  logic [5:0]  w;
  logic [31:0] mask;
  logic [31:0] x;
  logic        xneg;
  logic [31:0] mag;
  logic [4:0]  p;
  logic [7:0]  sh;
  logic [31:0] rem;
  logic [31:0] half;
  logic [24:0] mant;
  logic        rnd;
  logic [8:0]  ebias;
  logic [31:0] f2x_res;

  logic        fneg;
  logic [7:0]  fex;
  logic [22:0] ffr;
  logic [31:0] maxc;
  logic [31:0] minc;
  logic signed [9:0] k;
  logic [54:0] shl;
  logic [31:0] fmag;
  logic [31:0] x2f_res;
  logic        x2f_sat;

  always_comb begin
    unique case (word_size_t'(cfg.wsel))
      WS_8:    w = 6'd8;
      WS_16:   w = 6'd16;
      default: w = 6'd32;
    endcase
  end

  // fixed to float
  always_comb begin
    mask = (w == 6'd32) ? 32'hffff_ffff : ((32'd1 << w) - 32'd1);
    x    = req.operand_bits & mask;
    xneg = x[5'(w - 6'd1)];
    mag  = xneg ? ((32'd0 - x) & mask) : x;
    if (mag == 32'd0) mag = 32'd1 << (w - 6'd1);
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    ebias = 9'(p) + 9'd127 - 9'(cfg.frac);
    sh    = 8'd0;
    rem   = 32'd0;
    half  = 32'd0;
    rnd   = 1'b0;
    if (p > 5'd23) begin
      sh   = 8'(p) - 8'd23;
      rem  = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 8'd1);
      mant = 25'(mag >> sh);
      rnd  = (rem > half) || ((rem == half) && mant[0]);
      mant = mant + 25'(rnd);
      if (mant[24]) begin
        mant  = mant >> 1;
        ebias = ebias + 9'd1;
      end
    end else begin
      mant = 25'(mag << (5'd23 - p));
    end
    if (x == 32'd0) f2x_res = 32'd0;
    else f2x_res = {xneg, ebias[7:0], mant[22:0]};
  end

  // float to fixed
  always_comb begin
    fneg = req.operand_bits[31];
    fex  = req.operand_bits[30:23];
    ffr  = req.operand_bits[22:0];
    maxc = (32'd1 << (w - 6'd1)) - 32'd1;
    minc = 32'd0 - (32'd1 << (w - 6'd1));
    k    = 10'(signed'({2'b0, fex})) - 10'sd150 + 10'(signed'({5'b0, cfg.frac}));
    shl  = '0;
    fmag = '0;
    x2f_sat = 1'b0;
    x2f_res = '0;
    if (fex == 8'hff) begin
      if (ffr == 23'd0) begin
        x2f_sat = 1'b1;
        x2f_res = fneg ? minc : maxc;
      end
    end else if (fex != 8'd0) begin
      if (k >= 10'(signed'({4'b0, w})) - 10'sd24) begin
        x2f_sat = 1'b1;
        x2f_res = fneg ? minc : maxc;
      end else begin
        if (k >= 10'sd0) shl = 55'({1'b1, ffr}) << k[4:0];
        else if (k > -10'sd24) shl = 55'({1'b1, ffr} >> (5'(-k)));
        fmag    = shl[31:0];
        x2f_res = fneg ? (32'd0 - fmag) : fmag;
      end
    end
  end

  always_comb begin
    if (action_t'(req.action) == ACT_FIX2FLT) begin
      rsp.result_bits = f2x_res;
      rsp.saturated   = 1'b0;
    end else begin
      rsp.result_bits = x2f_res;
      rsp.saturated   = x2f_sat;
    end
  end

endmodule

>>> hdl/fixed_float_converter.sv
// Fixed-point / float32 converter. One request per cycle absent back pressure;
// a request is captured in the input register, converted by one pass of
// combinational logic (leading-one search, rounding, barrel shift) and held
// in the result register. Ready stays high while the result register is
// empty or being drained, so full throughput holds under no back pressure.
// Write fraction_bits (index 0) and word_size_select (index 1) only when idle.
module fixed_float_converter
  import ffc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ffc_in_if.sink                in_ch,
  ffc_out_if.source             out_ch
);

  cfg_t cfg_r;
  logic in_vld_r;
  req_t in_r;
  logic out_vld_r;
  rsp_t out_r;
  rsp_t conv;
  logic stage_adv;

  // advance the input stage when the result register is free or draining
  assign stage_adv   = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || stage_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frac <= FRAC_RESET;
      cfg_r.wsel <= WS_32;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRACTION_BITS: cfg_r.frac <= cfg_data[4:0];
        REG_WORD_SIZE:     cfg_r.wsel <= cfg_data[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_r <= in_ch.req;
  end

  ffc_convert u_conv (
    .req (in_r),
    .cfg (cfg_r),
    .rsp (conv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && in_vld_r) out_r <= conv;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.rsp   = out_r;

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_r))
    else $error("result dropped under stall");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !stage_adv |=> in_vld_r)
    else $error("input stage lost request");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ch.ready)
    else $error("not ready while empty");

endmodule

>>> sim/fixed_float_converter_tb.sv
module fixed_float_converter_tb;
  import ffc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ffc_in_if  in_ch ();
  ffc_out_if out_ch ();

  fixed_float_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Shadow copy of the converter's configuration registers.
  logic [4:0] frac_sel = FRAC_RESET;
  word_size_t wsize_sel = WS_32;

  req_t req_queue[$];    // requests waiting to be driven
  rsp_t expected_rsp[$]; // predicted responses, oldest first
  int   error_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned word_bits(input word_size_t ws);
    case (ws)
      WS_8:    return 8;
      WS_16:   return 16;
      default: return 32;
    endcase
  endfunction

  // Signed fixed word to float32, round to nearest even.
  function automatic logic [31:0] fix_to_f32(input logic [31:0] raw,
                                             input int unsigned w, input int f);
    logic [31:0] mask, x, mag, mant, rem, half;
    logic        neg;
    int          p, ex, sh;
    mask = (w == 32) ? 32'hffff_ffff : ((32'd1 << w) - 1);
    x    = raw & mask;
    neg  = x[w-1];
    if (x == 0) return 32'd0;
    mag = neg ? ((32'd0 - x) & mask) : x;
    if (mag == 0) mag = 32'd1 << (w - 1);
    p = 31;
    while (mag[p] == 1'b0) p--;
    ex = p - f;
    if (p > 23) begin
      sh   = p - 23;
      rem  = mag & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      mant = mag >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant[24]) begin
        mant = mant >> 1;
        ex++;
      end
    end else begin
      mant = mag << (23 - p);
    end
    return {neg, 8'(ex + 127), mant[22:0]};
  endfunction

  // Float32 to signed fixed word, truncate toward zero, clamp at the limits.
  function automatic rsp_t f32_to_fix(input logic [31:0] bits,
                                      input int unsigned w, input int f);
    rsp_t        r;
    logic [31:0] maxc, minc;
    logic [63:0] m, mag;
    int          k;
    maxc = (32'd1 << (w - 1)) - 1;
    minc = 32'd0 - (32'd1 << (w - 1));
    r = '0;
    if (bits[30:23] == 8'hff) begin
      if (bits[22:0] != 0) return r;
      r.saturated   = 1'b1;
      r.result_bits = bits[31] ? minc : maxc;
      return r;
    end
    if (bits[30:23] == 8'h00) return r;
    m = {41'd1, bits[22:0]};
    k = int'(bits[30:23]) - 150 + f;
    if (k >= int'(w) - 24) begin
      r.saturated   = 1'b1;
      r.result_bits = bits[31] ? minc : maxc;
      return r;
    end
    if (k >= 0) mag = m << k;
    else if (k > -24) mag = m >> (-k);
    else mag = 0;
    r.result_bits = bits[31] ? (32'd0 - mag[31:0]) : mag[31:0];
    return r;
  endfunction

  function automatic rsp_t convert(input req_t rq);
    rsp_t r;
    int unsigned w;
    w = word_bits(wsize_sel);
    if (rq.action == ACT_FIX2FLT) begin
      r.result_bits = fix_to_f32(rq.operand_bits, w, int'(frac_sel));
      r.saturated   = 1'b0;
    end else begin
      r = f32_to_fix(rq.operand_bits, w, int'(frac_sel));
    end
    return r;
  endfunction

  // Driver: pop a request, hold a random gap, keep valid up until accepted.
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.req   <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the pending request
    end else begin
      if (in_ch.valid) begin
        expected_rsp.push_back(convert(in_ch.req));
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        in_ch.req   <= req_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1)) in_gap = 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted response, then draw the next stall.
  int unsigned out_stall = 0;
  bit burst_mode = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected response %h", out_ch.rsp.result_bits));
        end else begin
          rsp_t exp_r;
          exp_r = expected_rsp.pop_front();
          if (out_ch.rsp.result_bits !== exp_r.result_bits)
            report_mismatch($sformatf("result_bits got %h exp %h",
                                      out_ch.rsp.result_bits, exp_r.result_bits));
          if (out_ch.rsp.saturated !== exp_r.saturated)
            report_mismatch($sformatf("saturated got %b exp %b (result %h)",
                                      out_ch.rsp.saturated, exp_r.saturated,
                                      exp_r.result_bits));
        end
        if ($urandom_range(0, 31) == 0) burst_mode = ~burst_mode;
        out_stall = burst_mode ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1)) out_stall = 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FRACTION_BITS) frac_sel = val;
    else wsize_sel = word_size_t'(val[1:0]);
  endtask

  // Drain: wait until all queued requests are accepted and answered.
  task automatic wait_idle();
    while (req_queue.size() > 0 || in_ch.valid || expected_rsp.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_t mk_req(input action_t a, input logic [31:0] v);
    req_t r;
    r.action       = a;
    r.operand_bits = v;
    return r;
  endfunction

  // Random float near the saturation edge of the current setting.
  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    int center;
    center = 150 - int'(frac_sel) + int'(word_bits(wsize_sel)) - 24;
    case ($urandom_range(0, 9))
      0:       ex = 8'hff;
      1:       ex = 8'h00;
      2:       ex = 8'($urandom);
      default: ex = 8'(center + $urandom_range(0, 40) - 30);
    endcase
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  task automatic queue_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 1)) req_queue.push_back(mk_req(ACT_FLT2FIX, rand_float()));
      else req_queue.push_back(mk_req(ACT_FIX2FLT, $urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset setting (32-bit words, 16 fraction bits).
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'h0000_0000));
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'h7fff_ffff));
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'h8000_0000));
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'hffff_ffff));
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'h0100_0180));
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'h0100_0080));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h4700_0000)); // exact positive limit
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'hc700_0000)); // exact negative limit
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h46ff_fffe));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h7fc0_0001)); // NaN
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h7f80_0000)); // +inf
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'hff80_0000)); // -inf
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h0000_0000));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h8000_0000));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h007f_ffff)); // subnormal
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'hbf80_0000));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h3380_0000)); // below one LSB
    wait_idle();

    // 8-bit words: high bits ignored, word-size extremes.
    write_reg(REG_WORD_SIZE, 5'(WS_8));
    write_reg(REG_FRACTION_BITS, 5'd0);
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'hffff_ff80));
    req_queue.push_back(mk_req(ACT_FIX2FLT, 32'h1234_567f));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h4300_0000));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'hc300_0000));
    req_queue.push_back(mk_req(ACT_FLT2FIX, 32'h42fe_0000));
    wait_idle();

    // Sweep through settings, including word select three and the fraction extremes.
    for (int ph = 0; ph < 12; ph++) begin
      logic [4:0] fsel;
      logic [1:0] wsel;
      wsel = ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3));
      case (ph % 3)
        0:       fsel = 5'd0;
        1:       fsel = 5'd31;
        default: fsel = 5'($urandom);
      endcase
      write_reg(REG_WORD_SIZE, 5'(wsel));
      write_reg(REG_FRACTION_BITS, fsel);
      queue_random(36);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("fixed_float_converter verification clean");
    end else begin
      $display("fixed_float_converter verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2ms;
    $display("fixed_float_converter verification failed");
    $finish;
  end

endmodule

>>> files.f
hdl/ffc_pkg.sv
hdl/ffc_if.sv
hdl/ffc_convert.sv
hdl/fixed_float_converter.sv
sim/fixed_float_converter_tb.sv
